// ===== rtl/core/bwf_pkg.sv =====
// Shared types and constants of the best/worst-fit segment allocator.
// Used by every module in rtl/core; depends on nothing.
package bwf_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int SIZE_BITS    = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int OWNER_W      = 16;
    localparam int PLACE_W      = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [SIZE_BITS-1:0] TOTAL_SIZE_RESET = SIZE_BITS'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIT_MODE   = 2'd0,
        REG_TOTAL_SIZE = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DRAIN,
        S_WR_LEFT,
        S_WR_PICK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [15:0] owner_id;
        logic [15:0] request_size;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  placed_index;
        logic [15:0] leftover_size;
    } rsp_t;

    typedef struct packed {
        logic [OWNER_W-1:0]   owner;
        logic                 used;
        logic [SIZE_BITS-1:0] size;
    } seg_entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        seg_entry_t       wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// ===== rtl/core/best_worst_fit_segment_allocator.sv =====
// Best-fit / worst-fit segment allocator, top level.
// Depends on bwf_pkg, bwf_seg_ram and bwf_ctrl.
//
// A request is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high, and the receiver
// must take it then. A request scans the count entries of the table through
// the single read port of the segment RAM (count is the number of table
// entries), then moves the entries behind the chosen segment one place up
// and writes the split segments before it presents the result. A request
// that finds no fit or a full table answers in the cycle right after the
// scan. A zero-size request answers with no fit and skips the scan. After
// reset the block loads the first table entry before it drops busy.
// Configuration writes are taken whenever no request is in progress;
// writing total_size reloads the table as one free segment.
module best_worst_fit_segment_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  bwf_pkg::req_t                    request,
    output logic                             busy,
    output logic                             done,
    output bwf_pkg::rsp_t                    result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bwf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bwf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bwf_pkg::mem_req_t   mem_req;
    bwf_pkg::seg_entry_t rd_data;

    bwf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    bwf_seg_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a request");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    a_cfg_not_during_request: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !done)
        else $error("configuration transfer open while result pending");

endmodule

// ===== rtl/core/bwf_seg_ram.sv =====
// Segment table storage: one write port, one read port with registered data.
// Depends on bwf_pkg.
module bwf_seg_ram (
    input  logic                clk,
    input  bwf_pkg::mem_req_t   mem_req,
    output bwf_pkg::seg_entry_t rd_data
);

    bwf_pkg::seg_entry_t mem [bwf_pkg::MAX_SEGMENTS];

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.rd_en)
        begin
            rd_data <= mem[mem_req.rd_addr];
        end
    end

endmodule

// ===== rtl/core/bwf_fit_unit.sv =====
// Shared compare and subtract unit: judges one candidate segment against the
// request and the current pick, and forms the leftover. Depends on bwf_pkg.
module bwf_fit_unit (
    input  bwf_pkg::seg_entry_t            cand,
    input  logic [bwf_pkg::SIZE_BITS-1:0]  amount,
    input  logic [bwf_pkg::SIZE_BITS-1:0]  best_size,
    input  logic                           fit_mode,
    input  logic                           found,
    output logic                           take,
    output logic [bwf_pkg::SIZE_BITS-1:0]  leftover
);

    logic fits;
    logic better;

    always_comb
    begin
        fits     = !cand.used && (cand.size >= amount);
        better   = fit_mode ? (cand.size >= best_size) : (cand.size <= best_size);
        take     = fits && (!found || better);
        leftover = best_size - amount;
    end

endmodule

// ===== rtl/core/bwf_ctrl.sv =====
// Sequencer of the allocator: configuration registers, table scan, insert
// shift and result register. Depends on bwf_pkg and bwf_fit_unit.
module bwf_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  bwf_pkg::req_t                        request,
    output logic                                 busy,
    output logic                                 done,
    output bwf_pkg::rsp_t                        result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bwf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bwf_pkg::CFG_DATA_W-1:0]       cfg_data,
    output bwf_pkg::mem_req_t                    mem_req,
    input  bwf_pkg::seg_entry_t                  rd_data
);

    bwf_pkg::state_t                    state_reg, state_next;
    logic                               fit_mode_reg, fit_mode_next;
    logic [bwf_pkg::SIZE_BITS-1:0]      total_size_reg, total_size_next;
    logic [bwf_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [bwf_pkg::OWNER_W-1:0]        owner_reg, owner_next;
    logic [bwf_pkg::SIZE_BITS-1:0]      amount_reg, amount_next;
    logic [bwf_pkg::CNT_W-1:0]          scan_reg, scan_next;
    logic                               rvalid_reg, rvalid_next;
    logic [bwf_pkg::IDX_W-1:0]          ridx_reg, ridx_next;
    logic                               found_reg, found_next;
    logic [bwf_pkg::IDX_W-1:0]          pick_reg, pick_next;
    logic [bwf_pkg::SIZE_BITS-1:0]      pick_size_reg, pick_size_next;
    logic [bwf_pkg::OWNER_W-1:0]        pick_owner_reg, pick_owner_next;
    logic [bwf_pkg::IDX_W-1:0]          cursor_reg, cursor_next;
    bwf_pkg::rsp_t                      rsp_reg, rsp_next;

    logic                               cfg_fire;
    logic                               take;
    logic [bwf_pkg::SIZE_BITS-1:0]      leftover;
    logic [bwf_pkg::IDX_W-1:0]          pick_plus1;

    bwf_fit_unit u_fit (
        .cand      (rd_data),
        .amount    (amount_reg),
        .best_size (pick_size_reg),
        .fit_mode  (fit_mode_reg),
        .found     (found_reg),
        .take      (take),
        .leftover  (leftover)
    );

    assign pick_plus1 = pick_reg + bwf_pkg::IDX_W'(1);
    assign cfg_ready  = (state_reg == bwf_pkg::S_IDLE) || (state_reg == bwf_pkg::S_INIT);
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign busy       = (state_reg != bwf_pkg::S_IDLE);
    assign done       = (state_reg == bwf_pkg::S_RESP);
    assign result     = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bwf_pkg::S_INIT;
            fit_mode_reg   <= 1'b0;
            total_size_reg <= bwf_pkg::TOTAL_SIZE_RESET;
            count_reg      <= bwf_pkg::CNT_W'(1);
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fit_mode_reg   <= fit_mode_next;
            total_size_reg <= total_size_next;
            count_reg      <= count_next;
            rvalid_reg     <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg      <= owner_next;
        amount_reg     <= amount_next;
        scan_reg       <= scan_next;
        ridx_reg       <= ridx_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pick_size_reg  <= pick_size_next;
        pick_owner_reg <= pick_owner_next;
        cursor_reg     <= cursor_next;
        rsp_reg        <= rsp_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        fit_mode_next   = fit_mode_reg;
        total_size_next = total_size_reg;
        count_next      = count_reg;
        owner_next      = owner_reg;
        amount_next     = amount_reg;
        scan_next       = scan_reg;
        rvalid_next     = 1'b0;
        ridx_next       = ridx_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_size_next  = pick_size_reg;
        pick_owner_next = pick_owner_reg;
        cursor_next     = cursor_reg;
        rsp_next        = rsp_reg;
        mem_req         = '0;

        if (cfg_fire)
        begin
            unique case (cfg_index)
                bwf_pkg::REG_FIT_MODE:
                begin
                    fit_mode_next = cfg_data[0];
                end
                bwf_pkg::REG_TOTAL_SIZE:
                begin
                    total_size_next      = cfg_data[bwf_pkg::SIZE_BITS-1:0];
                    count_next           = bwf_pkg::CNT_W'(1);
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = '0;
                    mem_req.wr_data      = '0;
                    mem_req.wr_data.size = cfg_data[bwf_pkg::SIZE_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            bwf_pkg::S_INIT:
            begin
                if (!(cfg_fire && cfg_index == bwf_pkg::REG_TOTAL_SIZE))
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = '0;
                    mem_req.wr_data      = '0;
                    mem_req.wr_data.size = total_size_reg;
                end
                state_next = bwf_pkg::S_IDLE;
            end

            bwf_pkg::S_IDLE:
            begin
                if (start)
                begin
                    owner_next  = request.owner_id;
                    amount_next = request.request_size;
                    scan_next   = '0;
                    found_next  = 1'b0;
                    pick_next   = '0;
                    if (request.request_size == '0)
                    begin
                        rsp_next        = '0;
                        rsp_next.status = bwf_pkg::ST_NO_FIT;
                        state_next      = bwf_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = bwf_pkg::S_SCAN;
                    end
                end
            end

            bwf_pkg::S_SCAN:
            begin
                if (scan_reg < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg[bwf_pkg::IDX_W-1:0];
                    rvalid_next     = 1'b1;
                    ridx_next       = scan_reg[bwf_pkg::IDX_W-1:0];
                    scan_next       = scan_reg + bwf_pkg::CNT_W'(1);
                end
                if (rvalid_reg && take)
                begin
                    found_next      = 1'b1;
                    pick_next       = ridx_reg;
                    pick_size_next  = rd_data.size;
                    pick_owner_next = rd_data.owner;
                end
                if (!(scan_reg < count_reg) && !rvalid_reg)
                begin
                    rsp_next = '0;
                    if (!found_reg)
                    begin
                        rsp_next.status = bwf_pkg::ST_NO_FIT;
                        state_next      = bwf_pkg::S_RESP;
                    end
                    else if (count_reg == bwf_pkg::CNT_W'(bwf_pkg::MAX_SEGMENTS))
                    begin
                        rsp_next.status = bwf_pkg::ST_FULL;
                        state_next      = bwf_pkg::S_RESP;
                    end
                    else if (bwf_pkg::CNT_W'(pick_reg) + bwf_pkg::CNT_W'(1) < count_reg)
                    begin
                        cursor_next = bwf_pkg::IDX_W'(count_reg - bwf_pkg::CNT_W'(1));
                        state_next  = bwf_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = bwf_pkg::S_WR_LEFT;
                    end
                end
            end

            bwf_pkg::S_SHIFT:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cursor_reg;
                rvalid_next     = 1'b1;
                ridx_next       = cursor_reg;
                if (rvalid_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = ridx_reg + bwf_pkg::IDX_W'(1);
                    mem_req.wr_data = rd_data;
                end
                if (cursor_reg == pick_plus1)
                begin
                    state_next = bwf_pkg::S_DRAIN;
                end
                else
                begin
                    cursor_next = cursor_reg - bwf_pkg::IDX_W'(1);
                end
            end

            bwf_pkg::S_DRAIN:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ridx_reg + bwf_pkg::IDX_W'(1);
                mem_req.wr_data = rd_data;
                state_next      = bwf_pkg::S_WR_LEFT;
            end

            bwf_pkg::S_WR_LEFT:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = pick_plus1;
                mem_req.wr_data.owner = pick_owner_reg;
                mem_req.wr_data.used  = 1'b0;
                mem_req.wr_data.size  = leftover;
                rsp_next.leftover_size = leftover;
                state_next            = bwf_pkg::S_WR_PICK;
            end

            bwf_pkg::S_WR_PICK:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = pick_reg;
                mem_req.wr_data.owner = owner_reg;
                mem_req.wr_data.used  = 1'b1;
                mem_req.wr_data.size  = amount_reg;
                count_next            = count_reg + bwf_pkg::CNT_W'(1);
                rsp_next.status       = bwf_pkg::ST_GRANTED;
                rsp_next.placed_index = bwf_pkg::PLACE_W'(pick_reg);
                state_next            = bwf_pkg::S_RESP;
            end

            bwf_pkg::S_RESP:
            begin
                state_next = bwf_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bwf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the best/worst-fit segment allocator.
// Predicts every allocation answer from a private table model and checks
// each done strobe against it; depends on bwf_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;

    localparam logic [bwf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [bwf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    bwf_pkg::req_t                  request = '0;
    logic                           busy;
    logic                           done;
    bwf_pkg::rsp_t                  result;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bwf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bwf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // allocator table as the block should hold it
    logic [15:0] tbl_owner [bwf_pkg::MAX_SEGMENTS];
    logic        tbl_used [bwf_pkg::MAX_SEGMENTS];
    logic [15:0] tbl_size [bwf_pkg::MAX_SEGMENTS];
    int          tbl_count;
    logic        worst_fit;
    logic [15:0] mem_total;

    bwf_pkg::rsp_t alloc_answers [$];
    bwf_pkg::rsp_t head_answer;

    int idle_pct;
    int mismatches;
    int n_requests;
    int n_granted;
    int n_no_fit;
    int n_full;
    int n_reg_writes;
    int n_worst_requests;

    best_worst_fit_segment_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void reload_table();
        int i;
        for (i = 0; i < bwf_pkg::MAX_SEGMENTS; i++)
        begin
            tbl_owner[i] = '0;
            tbl_used[i]  = 1'b0;
            tbl_size[i]  = '0;
        end
        tbl_size[0] = mem_total;
        tbl_count   = 1;
    endfunction

    function automatic bwf_pkg::rsp_t allocate(bwf_pkg::req_t r);
        bwf_pkg::rsp_t o;
        bit   found;
        int   pick;
        int   i;
        o.status        = bwf_pkg::ST_NO_FIT;
        o.placed_index  = '0;
        o.leftover_size = '0;
        found = 1'b0;
        pick  = 0;
        if (r.request_size != 0)
        begin
            for (i = 0; i < tbl_count; i++)
            begin
                if (!tbl_used[i] && tbl_size[i] >= r.request_size)
                begin
                    if (!found)
                    begin
                        found = 1'b1;
                        pick  = i;
                    end
                    else if (!worst_fit)
                    begin
                        if (tbl_size[i] <= tbl_size[pick])
                            pick = i;
                    end
                    else if (tbl_size[i] >= tbl_size[pick])
                    begin
                        pick = i;
                    end
                end
            end
        end
        if (!found)
            return o;
        if (tbl_count >= bwf_pkg::MAX_SEGMENTS)
        begin
            o.status = bwf_pkg::ST_FULL;
            return o;
        end
        for (i = tbl_count; i > pick; i--)
        begin
            tbl_owner[i] = tbl_owner[i-1];
            tbl_used[i]  = tbl_used[i-1];
            tbl_size[i]  = tbl_size[i-1];
        end
        tbl_owner[pick]  = r.owner_id;
        tbl_used[pick]   = 1'b1;
        tbl_size[pick]   = r.request_size;
        tbl_size[pick+1] = tbl_size[pick+1] - r.request_size;
        tbl_count++;
        o.status        = bwf_pkg::ST_GRANTED;
        o.placed_index  = 5'(pick);
        o.leftover_size = tbl_size[pick+1];
        return o;
    endfunction

    // sizes scaled to the last segment's room, or random, extreme or zero
    function automatic logic [15:0] pick_size(int small_pct);
        logic [15:0] room;
        int          roll;
        room = tbl_size[tbl_count-1];
        if ($urandom_range(99) < small_pct)
            return 16'($urandom_range(1, room / 24 + 1));
        roll = $urandom_range(99);
        if (roll < 35)
            return (room == 0) ? 16'd1 : room;
        if (roll < 55)
            return room + 16'd1;
        if (roll < 85)
            return 16'($urandom);
        if (roll < 93)
            return roll[0] ? 16'hFFFF : 16'd1;
        return 16'd0;
    endfunction

    task automatic send_request(input logic [15:0] owner, input logic [15:0] amount);
        bwf_pkg::req_t r;
        bwf_pkg::rsp_t want;
        bit   taken;
        r.owner_id     = owner;
        r.request_size = amount;
        taken   = 1'b0;
        request <= r;
        while (!taken)
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            taken = start && (busy === 1'b0);
        end
        want = allocate(r);
        alloc_answers.push_back(want);
        n_requests++;
        if (worst_fit)
            n_worst_requests++;
        case (want.status)
            bwf_pkg::ST_GRANTED: n_granted++;
            bwf_pkg::ST_FULL:    n_full++;
            default:             n_no_fit++;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        while (alloc_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [bwf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bwf_pkg::CFG_DATA_W-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        n_reg_writes++;
        case (idx)
            bwf_pkg::REG_FIT_MODE:
                worst_fit = data[0];
            bwf_pkg::REG_TOTAL_SIZE:
            begin
                mem_total = data;
                reload_table();
            end
            default: ;
        endcase
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_table();
        send_request(16'h0000, 16'd0);
        send_request(16'hFFFF, 16'd1);
        send_request(16'h0001, 16'hFFFF);
        send_request(16'h8000, 16'd1023);
        send_request(16'h7FFF, 16'd1);
    endtask

    task automatic test_size_extremes();
        drain();
        write_reg(bwf_pkg::REG_FIT_MODE, 16'h0000, 1'b0);
        write_reg(bwf_pkg::REG_TOTAL_SIZE, 16'hFFFF, 1'b1);
        send_request(16'hA5A5, 16'hFFFF);
        drain();
        write_reg(bwf_pkg::REG_TOTAL_SIZE, 16'hFFFF, 1'b1);
        send_request(16'h5A5A, 16'd1);
        send_request(16'h0F0F, 16'hFFFE);
        drain();
        write_reg(bwf_pkg::REG_TOTAL_SIZE, 16'h0000, 1'b1);
        send_request(16'h1234, 16'd1);
        send_request(16'hFEDC, 16'd0);
    endtask

    task automatic test_fit_modes();
        drain();
        write_reg(bwf_pkg::REG_FIT_MODE, 16'hFFFF, 1'b0);
        write_reg(bwf_pkg::REG_TOTAL_SIZE, 16'd5000, 1'b1);
        send_request(16'($urandom), 16'd1000);
        send_request(16'($urandom), 16'd2500);
        drain();
        write_reg(bwf_pkg::REG_FIT_MODE, 16'hFFFE, 1'b1);
        send_request(16'($urandom), 16'd1500);
        send_request(16'($urandom), 16'd1);
        send_request(16'($urandom), 16'd0);
    endtask

    task automatic test_register_space();
        drain();
        write_reg(bwf_pkg::REG_TOTAL_SIZE, 16'($urandom), 1'b0);
        write_reg(REG_SPARE_2, 16'($urandom), 1'b0);
        write_reg(REG_SPARE_3, 16'($urandom), 1'b1);
        send_request(16'($urandom), pick_size(60));
        send_request(16'($urandom), pick_size(60));
    endtask

    task automatic test_table_full();
        int pass;
        int k;
        for (pass = 0; pass < 2; pass++)
        begin
            drain();
            write_reg(bwf_pkg::REG_FIT_MODE, 16'($urandom), 1'b0);
            write_reg(bwf_pkg::REG_TOTAL_SIZE, 16'($urandom_range(64, 65535)), 1'b1);
            for (k = 0; k < bwf_pkg::MAX_SEGMENTS - 1; k++)
                send_request(16'($urandom), pick_size(100));
            for (k = 0; k < 8; k++)
                send_request(16'($urandom), pick_size(20));
        end
    endtask

    task automatic test_random_mix(input int pct, input int budget);
        int   goal;
        int   n;
        int   k;
        bit   do_total;
        bit   do_spare;
        logic [15:0] total;
        idle_pct = pct;
        goal = n_requests + budget;
        while (n_requests < goal)
        begin
            drain();
            do_total = ($urandom_range(99) < 85);
            do_spare = ($urandom_range(99) < 10);
            case ($urandom_range(19))
                0:       total = 16'h0000;
                1:       total = 16'hFFFF;
                2, 3, 4: total = 16'($urandom);
                default: total = 16'($urandom_range(32, 3000));
            endcase
            write_reg(bwf_pkg::REG_FIT_MODE, 16'($urandom), !(do_total || do_spare));
            if (do_total)
                write_reg(bwf_pkg::REG_TOTAL_SIZE, total, !do_spare);
            if (do_spare)
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom), 1'b1);
            n = $urandom_range(8, 40);
            for (k = 0; k < n; k++)
            begin
                send_request(16'($urandom), pick_size(50));
                if ($urandom_range(99) < 3)
                    drain();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (alloc_answers.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status=%0d",
                         $time, result.status);
                $display("%0t: unexpected result: actual index=%0d left=%0d",
                         $time, result.placed_index, result.leftover_size);
                mismatches++;
            end
            else
            begin
                head_answer = alloc_answers.pop_front();
                if (result.status !== head_answer.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, head_answer.status, result.status);
                    mismatches++;
                end
                if (result.placed_index !== head_answer.placed_index)
                begin
                    $display("%0t: placed_index mismatch: expected %0d, actual %0d",
                             $time, head_answer.placed_index, result.placed_index);
                    mismatches++;
                end
                if (result.leftover_size !== head_answer.leftover_size)
                begin
                    $display("%0t: leftover_size mismatch: expected %0d, actual %0d",
                             $time, head_answer.leftover_size, result.leftover_size);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", alloc_answers.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        idle_pct         = 0;
        mismatches       = 0;
        n_requests       = 0;
        n_granted        = 0;
        n_no_fit         = 0;
        n_full           = 0;
        n_reg_writes     = 0;
        n_worst_requests = 0;
        worst_fit        = 1'b0;
        mem_total        = bwf_pkg::TOTAL_SIZE_RESET;
        reload_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_table();
        test_size_extremes();
        test_fit_modes();
        test_register_space();
        test_table_full();
        test_random_mix(0, 340);
        test_random_mix(76, 340);
        test_random_mix(0, 340);
        test_random_mix(17, 340);

        drain();
        repeat (80) @(posedge clk);
        $display("Covered %0d requests (%0d granted, %0d no fit, %0d table full),",
                 n_requests, n_granted, n_no_fit, n_full);
        $display("%0d in worst fit, with %0d register transfers, including reloads at sizes 0 and 65535",
                 n_worst_requests, n_reg_writes);
        if (mismatches == 0 && alloc_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== best_worst_fit_segment_allocator.f =====
rtl/core/bwf_pkg.sv
rtl/core/bwf_seg_ram.sv
rtl/core/bwf_fit_unit.sv
rtl/core/bwf_ctrl.sv
rtl/core/best_worst_fit_segment_allocator.sv
tb/sv/tb.sv
